// File: hw/rtl/srp_pkg.sv
// Shared types and helpers for the S-record line parser.
`default_nettype none

package srp_pkg;

  localparam int unsigned CharW = 8;
  localparam int unsigned AddrW = 16;
  localparam int unsigned DataW = 8;

  localparam logic [CharW-1:0] CharNewline = 8'd10;
  localparam logic [CharW-1:0] CharEndType = 8'h39;  // '9'
  localparam logic [CharW-1:0] CharLetterA = 8'h41;  // 'A'

  localparam logic [AddrW-1:0] AddrMax = 16'hFFFF;

  // Item held in the input register
  typedef struct packed {
    logic             valid;
    logic [CharW-1:0] char_in;
    logic             end_of_input;
  } in_item_t;

  // Hex digit value: letters are offset by 55, everything else by 48, mod 16
  function automatic logic [3:0] hex_digit(input logic [CharW-1:0] c);
    logic [3:0] v;
    if (c >= CharLetterA) begin
      v = c[3:0] + 4'd9;
    end else begin
      v = c[3:0];
    end
    return v;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/srecord_line_parser.sv
// S-record line parser: decodes 16-bit-address data records (any type but 9) into byte writes and a bound summary.
//
// Input channel (in_valid_i/in_ready_o) carries one ASCII character per item in
// char_in_i; end_of_input_i marks the end of the stream and the character is then
// ignored. Output channel (out_valid_o/out_ready_i) carries at most one result per
// input item: a byte write (kind_o = 0, write_address_o/write_data_o) for each
// second hex digit of a data byte, or an address summary (kind_o = 1,
// lowest_address_o/highest_address_o) on a '9' record type or end of input.
// Throughput: one character per cycle while results are taken; the next-state logic is a
// single pass between the input register and the result register.
// A character sits in the input register until the result register is free, then any
// result it gives is loaded into the result register.
// Reset clears the parser to line start, lowest bound 0xFFFF, highest bound 0.
// After the summary every later item is consumed with no result.
// When the receiver stalls, the result is held, the input register holds one more
// item, and then in_ready_o falls until the result is taken.
`default_nettype none

module srecord_line_parser (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic [srp_pkg::CharW-1:0] char_in_i,
  input  wire logic                      end_of_input_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic                           kind_o,
  output logic [srp_pkg::AddrW-1:0]      write_address_o,
  output logic [srp_pkg::DataW-1:0]      write_data_o,
  output logic [srp_pkg::AddrW-1:0]      lowest_address_o,
  output logic [srp_pkg::AddrW-1:0]      highest_address_o
);

  srp_pkg::in_item_t item;
  logic              advance;

  srp_in_stage u_in_stage (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .char_in_i      (char_in_i),
    .end_of_input_i (end_of_input_i),
    .advance_i      (advance),
    .item_o         (item)
  );

  srp_parser u_parser (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .item_i            (item),
    .advance_o         (advance),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .kind_o            (kind_o),
    .write_address_o   (write_address_o),
    .write_data_o      (write_data_o),
    .lowest_address_o  (lowest_address_o),
    .highest_address_o (highest_address_o)
  );

endmodule

`default_nettype wire

// File: hw/rtl/srp_in_stage.sv
// Input register stage of the S-record line parser.
`default_nettype none

module srp_in_stage (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic [srp_pkg::CharW-1:0] char_in_i,
  input  wire logic                      end_of_input_i,
  input  wire logic                      advance_i,
  output srp_pkg::in_item_t              item_o
);

  logic                      valid_q;
  logic [srp_pkg::CharW-1:0] char_q;
  logic                      eoi_q;

  // Take a new item when empty or when the held item moves on this cycle
  assign in_ready_o = !valid_q || advance_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // Capture payload on accept
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      char_q <= char_in_i;
      eoi_q  <= end_of_input_i;
    end
  end

  assign item_o.valid        = valid_q;
  assign item_o.char_in      = char_q;
  assign item_o.end_of_input = eoi_q;

endmodule

`default_nettype wire

// File: hw/rtl/srp_parser.sv
// Line state machine, address bounds and result register of the S-record parser.
`default_nettype none

module srp_parser (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  srp_pkg::in_item_t              item_i,
  output logic                           advance_o,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic                           kind_o,
  output logic [srp_pkg::AddrW-1:0]      write_address_o,
  output logic [srp_pkg::DataW-1:0]      write_data_o,
  output logic [srp_pkg::AddrW-1:0]      lowest_address_o,
  output logic [srp_pkg::AddrW-1:0]      highest_address_o
);

  localparam logic [2:0] PhLineStart = 3'd0;
  localparam logic [2:0] PhType      = 3'd1;
  localparam logic [2:0] PhCount     = 3'd2;
  localparam logic [2:0] PhAddr      = 3'd3;
  localparam logic [2:0] PhData      = 3'd4;
  localparam logic [2:0] PhSkip      = 3'd5;

  logic [2:0]                phase_q, phase_d;
  logic [1:0]                digit_q, digit_d;
  logic [15:0]               acc_q, acc_d;
  logic [7:0]                left_q, left_d;
  logic [srp_pkg::AddrW-1:0] cur_q, cur_d;
  logic [srp_pkg::AddrW-1:0] min_q, min_d;
  logic [srp_pkg::AddrW-1:0] max_q, max_d;
  logic                      fin_q, fin_d;

  logic                      out_valid_q;
  logic                      kind_q;
  logic [srp_pkg::AddrW-1:0] waddr_q;
  logic [srp_pkg::DataW-1:0] wdata_q;
  logic [srp_pkg::AddrW-1:0] low_q;
  logic [srp_pkg::AddrW-1:0] high_q;

  logic                      proc;
  logic                      res_valid;
  logic                      res_kind;
  logic [srp_pkg::DataW-1:0] res_data;
  logic [3:0]                dig;
  logic [15:0]               acc_shift;
  logic [17:0]               end_ext;

  // Move the held item on when the result register is free
  assign advance_o = !out_valid_q || out_ready_i;
  assign proc      = item_i.valid && advance_o;

  assign dig       = srp_pkg::hex_digit(item_i.char_in);
  assign acc_shift = {acc_q[11:0], dig};
  // Record end address: start + count - 4, signed over 18 bits
  assign end_ext   = {2'b00, acc_shift} + {10'd0, left_q} - 18'd4;

  // Next state for one character
  always_comb begin
    phase_d   = phase_q;
    digit_d   = digit_q;
    acc_d     = acc_q;
    left_d    = left_q;
    cur_d     = cur_q;
    min_d     = min_q;
    max_d     = max_q;
    fin_d     = fin_q;
    res_valid = 1'b0;
    res_kind  = 1'b0;
    res_data  = {acc_q[3:0], dig};
    if (fin_q) begin
      // drop everything after the end
    end else if (item_i.end_of_input) begin
      fin_d     = 1'b1;
      res_valid = 1'b1;
      res_kind  = 1'b1;
    end else if (item_i.char_in == srp_pkg::CharNewline) begin
      phase_d = PhLineStart;
      digit_d = 2'd0;
      acc_d   = 16'd0;
    end else begin
      case (phase_q)
        PhLineStart: begin
          phase_d = PhType;
        end
        PhType: begin
          if (item_i.char_in == srp_pkg::CharEndType) begin
            fin_d     = 1'b1;
            res_valid = 1'b1;
            res_kind  = 1'b1;
          end else begin
            phase_d = PhCount;
            digit_d = 2'd0;
            acc_d   = 16'd0;
          end
        end
        PhCount: begin
          if (digit_q >= 2'd1) begin
            left_d  = acc_shift[7:0];
            phase_d = PhAddr;
            digit_d = 2'd0;
            acc_d   = 16'd0;
          end else begin
            acc_d   = acc_shift;
            digit_d = digit_q + 2'd1;
          end
        end
        PhAddr: begin
          if (digit_q == 2'd3) begin
            cur_d = acc_shift;
            if (acc_shift < min_q) begin
              min_d = acc_shift;
            end
            if (left_q >= 8'd3) begin
              if (!end_ext[17] && (end_ext[16:0] > {1'b0, max_q})) begin
                max_d = end_ext[16] ? srp_pkg::AddrMax : end_ext[15:0];
              end
              left_d = left_q - 8'd3;
            end else begin
              left_d = 8'd0;
            end
            phase_d = ((left_q >= 8'd4)) ? PhData : PhSkip;
            digit_d = 2'd0;
            acc_d   = 16'd0;
          end else begin
            acc_d   = acc_shift;
            digit_d = digit_q + 2'd1;
          end
        end
        PhData: begin
          if (digit_q == 2'd0) begin
            acc_d   = {12'd0, dig};
            digit_d = 2'd1;
          end else begin
            res_valid = 1'b1;
            cur_d     = cur_q + 16'd1;
            left_d    = left_q - 8'd1;
            digit_d   = 2'd0;
            acc_d     = 16'd0;
            if (left_q == 8'd1) begin
              phase_d = PhSkip;
            end
          end
        end
        default: begin
          phase_d = PhSkip;
        end
      endcase
    end
  end

  // Advance parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhLineStart;
      digit_q <= 2'd0;
      acc_q   <= 16'd0;
      left_q  <= 8'd0;
      cur_q   <= '0;
      min_q   <= srp_pkg::AddrMax;
      max_q   <= '0;
      fin_q   <= 1'b0;
    end else if (proc) begin
      phase_q <= phase_d;
      digit_q <= digit_d;
      acc_q   <= acc_d;
      left_q  <= left_d;
      cur_q   <= cur_d;
      min_q   <= min_d;
      max_q   <= max_d;
      fin_q   <= fin_d;
    end
  end

  // Result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance_o) begin
      out_valid_q <= proc && res_valid;
    end
  end

  // Load result payload
  always_ff @(posedge clk_i) begin
    if (proc && res_valid) begin
      kind_q  <= res_kind;
      waddr_q <= res_kind ? '0 : cur_q;
      wdata_q <= res_kind ? '0 : res_data;
      low_q   <= res_kind ? min_q : '0;
      high_q  <= res_kind ? max_q : '0;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign kind_o            = kind_q;
  assign write_address_o   = waddr_q;
  assign write_data_o      = wdata_q;
  assign lowest_address_o  = low_q;
  assign highest_address_o = high_q;

  // No result after the summary
  a_no_result_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && fin_q |-> !res_valid)
    else $error("result produced after summary");

  // Data writes only come from the data phase
  a_write_in_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && res_valid && !res_kind |-> phase_q == PhData)
    else $error("data write outside data phase");

  // A summary leaves the parser finished
  a_summary_finishes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && res_valid && res_kind |=> fin_q)
    else $error("summary did not finish parse");

  // The lowest address never rises
  a_min_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc |=> min_q <= $past(min_q))
    else $error("lowest address increased");

endmodule

`default_nettype wire
